// ===== rtl/mdrh_pkg.sv =====
package mdrh_pkg;

	localparam int unsigned DIGIT_W = 64;
	localparam int unsigned MOD_W   = 62;
	localparam int unsigned CFG_IW  = 1;
	// width of the signed scratch words used for the compare-by-borrow selects
	localparam int unsigned EXT_W   = 65;

	localparam logic [CFG_IW-1:0] REG_MODULUS = 1'd0;
	localparam logic [CFG_IW-1:0] REG_RADIX   = 1'd1;

	localparam logic [MOD_W-1:0] MODULUS_RST = MOD_W'(2);
	localparam logic [MOD_W-1:0] RADIX_RST   = '0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_PREP,
		ST_MULT,
		ST_ADD
	} state_t;

	// one restoring step of r = (2r + b) mod q, r < q
	function automatic logic [MOD_W-1:0] red_step(
		input logic [MOD_W-1:0] r,
		input logic             b,
		input logic [MOD_W-1:0] q
	);
		logic [MOD_W:0]   t;
		logic [MOD_W+1:0] diff;
		t    = {r, b};
		diff = {1'b0, t} - {2'b00, q};
		if (diff[MOD_W+1])
			red_step = t[MOD_W-1:0];
		else
			red_step = diff[MOD_W-1:0];
	endfunction

endpackage

// ===== rtl/multidigit_to_residue_horner.sv =====
// Horner reduction of a number in the base held in the radix register, most
// significant digit first, to its residue modulo the value in the modulus
// register. Each digit word is loaded, then a bit-serial reducer brings the
// 64-bit digit and the radix register below the modulus (one bit a cycle, both
// side by side), the subtraction constants are formed, bit-serial double-and-add
// runs over the running residue, and a final modular add closes the step. Most
// of the time per digit goes to those two one-bit-a-cycle loops; no new digit
// is taken until the step is done. A residue word is emitted only for the
// digit marked last, after which the running residue returns to zero; it sits
// in an output register so the next number can start while it waits. A modulus
// below two gives a residue of zero. Write the modulus and radix only while idle.
module multidigit_to_residue_horner
	import mdrh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IW-1:0]     cfg_index,
	input  logic [MOD_W-1:0]      cfg_data,

	input  logic                  digit_valid,
	output logic                  digit_ready,
	input  logic [DIGIT_W-1:0]    digit,
	input  logic                  last_digit,

	output logic                  residue_valid,
	input  logic                  residue_ready,
	output logic [MOD_W-1:0]      residue
);

	localparam int unsigned CNT_W = $clog2(DIGIT_W);

	state_t state_q, state_d;

	logic [MOD_W-1:0]   modulus_q;
	logic [MOD_W-1:0]   radix_q;
	logic [MOD_W-1:0]   partial_q;

	logic [DIGIT_W-1:0] digit_sh_q;
	logic [DIGIT_W-1:0] radix_sh_q;
	logic [MOD_W-1:0]   mul_sh_q;
	logic               last_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [MOD_W-1:0]   rd_q;     // digit mod q
	logic [MOD_W-1:0]   ry_q;     // radix mod q
	logic [MOD_W-1:0]   rm_q;     // product accumulator
	logic [EXT_W-1:0]   negq_q;   // -q
	logic [EXT_W-1:0]   ym_q;     // y - q
	logic [EXT_W-1:0]   ym2_q;    // y - 2q
	logic [EXT_W-1:0]   dq_q;     // d - q

	logic [MOD_W-1:0]   residue_q;
	logic               residue_valid_q;

	logic               accept;
	logic               commit;
	logic               cnt_zero;

	logic [EXT_W-1:0]   dbl;
	logic [EXT_W-1:0]   c1, a0, a1, a2;
	logic [MOD_W-1:0]   mul_next;
	logic [EXT_W-1:0]   s0, s1;
	logic [MOD_W-1:0]   acc;

	assign cnt_zero = (cnt_q == '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (digit_valid)
					state_d = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (cnt_zero)
					state_d = ST_PREP;
			end
			ST_PREP: state_d = ST_MULT;
			ST_MULT: begin
				if (cnt_zero)
					state_d = ST_ADD;
			end
			ST_ADD: begin
				if (commit)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		digit_ready = 1'b0;
		commit      = 1'b0;
		case (state_q)
			ST_IDLE: digit_ready = 1'b1;
			ST_ADD:  commit = !last_q || !residue_valid_q || residue_ready;
			default: begin
				digit_ready = 1'b0;
				commit      = 1'b0;
			end
		endcase
	end

	assign accept = digit_valid && digit_ready;

	// double-and-add step: all candidates are one add from the doubled value
	always_comb begin
		dbl = {2'b00, rm_q, 1'b0};
		c1  = dbl + negq_q;
		a0  = dbl + {3'b000, ry_q};
		a1  = dbl + ym_q;
		a2  = dbl + ym2_q;
		if (mul_sh_q[MOD_W-1]) begin
			if (!a2[EXT_W-1])
				mul_next = a2[MOD_W-1:0];
			else if (!a1[EXT_W-1])
				mul_next = a1[MOD_W-1:0];
			else
				mul_next = a0[MOD_W-1:0];
		end else begin
			mul_next = c1[EXT_W-1] ? dbl[MOD_W-1:0] : c1[MOD_W-1:0];
		end
	end

	always_comb begin
		s0 = {3'b000, rm_q} + {3'b000, rd_q};
		s1 = {3'b000, rm_q} + dq_q;
		if (modulus_q < MOD_W'(2))
			acc = '0;
		else
			acc = s1[EXT_W-1] ? s0[MOD_W-1:0] : s1[MOD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			modulus_q       <= MODULUS_RST;
			radix_q         <= RADIX_RST;
			partial_q       <= '0;
			residue_valid_q <= 1'b0;
			cnt_q           <= '0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					REG_MODULUS: modulus_q <= cfg_data;
					REG_RADIX:   radix_q   <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE:   cnt_q <= CNT_W'(DIGIT_W - 1);
				ST_PREP:   cnt_q <= CNT_W'(MOD_W - 1);
				ST_REDUCE,
				ST_MULT:   cnt_q <= cnt_q - CNT_W'(1);
				default:   cnt_q <= cnt_q;
			endcase

			if (commit)
				partial_q <= last_q ? '0 : acc;

			if (commit && last_q)
				residue_valid_q <= 1'b1;
			else if (residue_ready)
				residue_valid_q <= 1'b0;
		end
	end

	// datapath words
	always_ff @(posedge clk) begin
		if (accept) begin
			digit_sh_q <= digit;
			radix_sh_q <= {{(DIGIT_W-MOD_W){1'b0}}, radix_q};
			last_q     <= last_digit;
			rd_q       <= '0;
			ry_q       <= '0;
		end
		if (state_q == ST_REDUCE) begin
			rd_q       <= red_step(rd_q, digit_sh_q[DIGIT_W-1], modulus_q);
			ry_q       <= red_step(ry_q, radix_sh_q[DIGIT_W-1], modulus_q);
			digit_sh_q <= {digit_sh_q[DIGIT_W-2:0], 1'b0};
			radix_sh_q <= {radix_sh_q[DIGIT_W-2:0], 1'b0};
		end
		if (state_q == ST_PREP) begin
			negq_q   <= {EXT_W{1'b0}} - {3'b000, modulus_q};
			ym_q     <= {3'b000, ry_q} - {3'b000, modulus_q};
			ym2_q    <= {3'b000, ry_q} - {2'b00, modulus_q, 1'b0};
			dq_q     <= {3'b000, rd_q} - {3'b000, modulus_q};
			mul_sh_q <= partial_q;
			rm_q     <= '0;
		end
		if (state_q == ST_MULT) begin
			rm_q     <= mul_next;
			mul_sh_q <= {mul_sh_q[MOD_W-2:0], 1'b0};
		end
		if (commit && last_q)
			residue_q <= acc;
	end

	assign residue_valid = residue_valid_q;
	assign residue       = residue_q;

endmodule
